// File: rtl/dott_pkg.sv
`default_nettype none

package dott_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam logic [31:0] WindowReset     = 32'd3600000;
  localparam logic [63:0] AllOnes         = '1;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_CANCEL  = 3'd1,
    REQ_REFRESH = 3'd2,
    REQ_RESET   = 3'd3,
    REQ_NEXT    = 3'd4,
    REQ_EXPIRE  = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_FIND,
    S_REFRESH,
    S_RESET1,
    S_RESET2,
    S_ROLL1,
    S_ROLL2,
    S_SCAN,
    S_POST,
    S_PICK,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/deadline_ordered_timer_table_unit.sv
`default_nettype none

// Timer table of NUM_SLOTS slots, driven by one request beat at a time and
// answering with result beats (tlast on the final one). Periods and deadlines
// sit in two small RAMs; a sequencer walks the slots one per cycle through a
// single shared 64-bit adder and a single 64-bit comparator. The input side
// is ready only between requests. Add, reset, next-time and expire can walk the
// slots through the deadline RAM read port, and expire walks them once more
// for every due slot.
module deadline_ordered_timer_table_unit
  import dott_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,   // rollover_window_ms
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type[2:0], slot[6:3], period_ms[38:7], recurring[39], restart_now[40],
  // now_ms[104:41], zero fill
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // ok[0], result_slot[4:1], remaining_ms[68:5], became_earliest[69],
  // any_active[70], zero fill
  output logic [71:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  state_e state_q, state_d;

  logic [2:0]  req_q, req_d;
  logic [3:0]  slot_q, slot_d;
  logic [31:0] per_q, per_d;
  logic        rec_q, rec_d;
  logic        fnow_q, fnow_d;
  logic [63:0] now_q, now_d;

  logic [NUM_SLOTS-1:0] active_q, active_d, rep_q, rep_d, due_q, due_d;
  logic        wake_q, wake_d;
  logic [63:0] prev_q, prev_d;
  logic [31:0] window_q, window_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          scan_due_q, scan_due_d;
  logic          best_vld_q, best_vld_d;
  logic [SW-1:0] best_idx_q, best_idx_d;
  logic [63:0]   best_dl_q, best_dl_d;
  logic [SW-1:0] tgt_q, tgt_d;
  logic [63:0]   acc_q, acc_d;
  logic          roll_q, roll_d;

  logic        res_ok_q, res_ok_d, res_early_q, res_early_d, res_last_q, res_last_d;
  logic [3:0]  res_slot_q, res_slot_d;
  logic [63:0] res_rem_q, res_rem_d;

  logic        out_vld_q, out_vld_d;
  logic [71:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  // shared arithmetic
  logic [63:0] add_a, add_b, add_sum;
  logic        add_sub;
  logic [63:0] cmp_a, cmp_b;
  logic        cmp_lt;

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {63'd0, add_sub};
  assign cmp_lt  = cmp_a < cmp_b;

  // RAM ports
  logic          dl_we, per_we;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [63:0]   dl_wdata, dl_rdata;
  logic [31:0]   per_rdata;

  dott_ram #(.Width(64), .Depth(NUM_SLOTS)) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (wr_addr),
    .wdata_i (dl_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dl_rdata)
  );

  dott_ram #(.Width(32), .Depth(NUM_SLOTS)) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (wr_addr),
    .wdata_i (per_q),
    .raddr_i (rd_addr),
    .rdata_o (per_rdata)
  );

  logic [31:0]   slot_ext, cnt_ext, cm1_ext, tgt_ext;
  logic [CW-1:0] cnt_m1;
  logic [SW-1:0] slot_idx, cnt_idx, ci;
  logic          slot_ok, cnt_end, any_on, emit_go, more, rst_same;
  logic [NUM_SLOTS-1:0] cand;

  assign slot_ext = 32'(slot_q);
  assign slot_idx = slot_ext[SW-1:0];
  assign slot_ok  = (slot_ext < NUM_SLOTS) && active_q[slot_idx];
  assign cnt_ext  = 32'(cnt_q);
  assign cnt_idx  = cnt_ext[SW-1:0];
  assign cnt_end  = (cnt_ext == NUM_SLOTS);
  assign cnt_m1   = cnt_q - {{(CW-1){1'b0}}, 1'b1};
  assign cm1_ext  = 32'(cnt_m1);
  assign ci       = cm1_ext[SW-1:0];
  assign tgt_ext  = 32'(tgt_q);
  assign any_on   = |active_q;
  assign emit_go  = !out_vld_q || m_axis_tready;
  assign more     = (req_q == REQ_EXPIRE) && !res_last_q;
  assign rst_same = (per_q == per_rdata) && !fnow_q;
  assign cand     = (req_q == REQ_EXPIRE) ? due_q : active_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (s_axis_tvalid) state_d = S_DECODE;
      S_DECODE: begin
        case (req_q)
          REQ_ADD:     state_d = S_ADD_FIND;
          REQ_REFRESH: state_d = slot_ok ? S_REFRESH : S_EMIT;
          REQ_RESET:   state_d = slot_ok ? S_RESET1 : S_EMIT;
          REQ_NEXT:    state_d = S_SCAN;
          REQ_EXPIRE:  state_d = any_on ? S_ROLL1 : S_EMIT;
          default:     state_d = S_EMIT;
        endcase
      end
      S_ADD_FIND: begin
        if (cnt_end) state_d = S_EMIT;
        else if (!active_q[cnt_idx]) state_d = S_SCAN;
      end
      S_REFRESH:  state_d = S_EMIT;
      S_RESET1:   state_d = rst_same ? S_EMIT : S_RESET2;
      S_RESET2:   state_d = S_SCAN;
      S_ROLL1:    state_d = S_ROLL2;
      S_ROLL2:    state_d = S_SCAN;
      S_SCAN:     if (cnt_end) state_d = S_POST;
      S_POST: begin
        if (req_q == REQ_EXPIRE) begin
          if (!scan_due_q) state_d = S_PICK;
          else if (due_q != '0) state_d = S_SCAN;
          else state_d = S_EMIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_PICK:     state_d = S_EMIT;
      S_EMIT:     if (emit_go) state_d = more ? S_SCAN : S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d = req_q; slot_d = slot_q; per_d = per_q; rec_d = rec_q;
    fnow_d = fnow_q; now_d = now_q;
    active_d = active_q; rep_d = rep_q; due_d = due_q;
    wake_d = wake_q; prev_d = prev_q; window_d = window_q;
    cnt_d = cnt_q; scan_due_d = scan_due_q;
    best_vld_d = best_vld_q; best_idx_d = best_idx_q; best_dl_d = best_dl_q;
    tgt_d = tgt_q; acc_d = acc_q; roll_d = roll_q;
    res_ok_d = res_ok_q; res_early_d = res_early_q; res_last_d = res_last_q;
    res_slot_d = res_slot_q; res_rem_d = res_rem_q;
    out_vld_d = out_vld_q; out_data_d = out_data_q; out_last_d = out_last_q;
    add_a = now_q; add_b = {32'd0, per_q}; add_sub = 1'b0;
    cmp_a = now_q; cmp_b = best_dl_q;
    dl_we = 1'b0; per_we = 1'b0; wr_addr = tgt_q; dl_wdata = add_sum;
    rd_addr = slot_idx;

    if (cfg_we_i) window_d = cfg_wdata_i;
    if (m_axis_tready) out_vld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d  = s_axis_tdata[2:0];
          slot_d = s_axis_tdata[6:3];
          per_d  = s_axis_tdata[38:7];
          rec_d  = s_axis_tdata[39];
          fnow_d = s_axis_tdata[40];
          now_d  = s_axis_tdata[104:41];
        end
      end
      S_DECODE: begin
        res_ok_d = 1'b0; res_slot_d = 4'd0; res_rem_d = 64'd0;
        res_early_d = 1'b0; res_last_d = 1'b1;
        tgt_d = slot_idx;
        cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b0;
        case (req_q)
          REQ_CANCEL: begin
            res_ok_d = slot_ok;
            if (slot_ok) active_d[slot_idx] = 1'b0;
          end
          REQ_NEXT: begin
            wake_d = 1'b0;
            res_ok_d = 1'b1;
          end
          default: ;
        endcase
      end
      S_ADD_FIND: begin
        wr_addr = cnt_idx;
        if (!cnt_end && !active_q[cnt_idx]) begin
          dl_we = 1'b1; per_we = 1'b1;
          active_d[cnt_idx] = 1'b1;
          rep_d[cnt_idx] = rec_q;
          tgt_d = cnt_idx;
          res_ok_d = 1'b1;
          res_slot_d = cnt_ext[3:0];
          cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b0;
        end else if (!cnt_end) begin
          cnt_d = cnt_q + {{(CW-1){1'b0}}, 1'b1};
        end
      end
      S_REFRESH: begin
        add_b = {32'd0, per_rdata};
        dl_we = 1'b1;
        res_ok_d = 1'b1;
      end
      S_RESET1: begin
        add_a = dl_rdata; add_b = {32'd0, per_rdata}; add_sub = 1'b1;
        acc_d = fnow_q ? now_q : add_sum;
        if (!rst_same) per_we = 1'b1;
      end
      S_RESET2: begin
        add_a = acc_q;
        dl_we = 1'b1;
        res_ok_d = 1'b1;
        cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b0;
      end
      S_ROLL1: begin
        add_a = prev_q; add_b = now_q; add_sub = 1'b1;
        acc_d = add_sum;
        cmp_a = now_q; cmp_b = prev_q;
        roll_d = cmp_lt;
      end
      S_ROLL2: begin
        cmp_a = {32'd0, window_q}; cmp_b = acc_q;
        roll_d = roll_q && cmp_lt;
        prev_d = now_q;
        due_d = '0;
        cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b1;
      end
      S_SCAN: begin
        rd_addr = cnt_idx;
        if (!cnt_end) cnt_d = cnt_q + {{(CW-1){1'b0}}, 1'b1};
        if (cnt_q != '0) begin
          if (scan_due_q) begin
            // due when deadline <= now, or on a clock rollover
            cmp_a = now_q; cmp_b = dl_rdata;
            due_d[ci] = active_q[ci] && (roll_q || !cmp_lt);
          end else begin
            cmp_a = dl_rdata; cmp_b = best_dl_q;
            if (cand[ci] && (!best_vld_q || cmp_lt)) begin
              best_vld_d = 1'b1; best_idx_d = ci; best_dl_d = dl_rdata;
            end
          end
        end
      end
      S_POST: begin
        rd_addr = best_idx_q;
        case (req_q)
          REQ_NEXT: begin
            add_a = best_dl_q; add_b = now_q; add_sub = 1'b1;
            cmp_a = now_q; cmp_b = best_dl_q;
            if (!best_vld_q) res_rem_d = AllOnes;
            else res_rem_d = cmp_lt ? add_sum : 64'd0;
          end
          REQ_EXPIRE: begin
            if (scan_due_q) begin
              cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b0;
            end else begin
              tgt_d = best_idx_q;
              due_d[best_idx_q] = 1'b0;
            end
          end
          default: begin
            // add or reset: flag the timer if it now leads the table and wake_q is clear
            if (best_vld_q && best_idx_q == tgt_q && !wake_q) begin
              res_early_d = 1'b1;
              wake_d = 1'b1;
            end
          end
        endcase
      end
      S_PICK: begin
        add_b = {32'd0, per_rdata};
        if (rep_q[tgt_q]) dl_we = 1'b1;
        else active_d[tgt_q] = 1'b0;
        res_ok_d = 1'b1;
        res_slot_d = tgt_ext[3:0];
        res_last_d = (due_q == '0);
      end
      S_EMIT: begin
        if (emit_go) begin
          out_vld_d = 1'b1;
          out_data_d = {1'b0, |(active_q & ~(due_q & ~rep_q)), res_early_q,
                        res_rem_q, res_slot_q, res_ok_q};
          out_last_d = res_last_q;
          if (more) begin
            cnt_d = '0; best_vld_d = 1'b0; scan_due_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      active_q   <= '0;
      rep_q      <= '0;
      due_q      <= '0;
      wake_q     <= 1'b0;
      prev_q     <= 64'd0;
      window_q   <= WindowReset;
      cnt_q      <= '0;
      scan_due_q <= 1'b0;
      best_vld_q <= 1'b0;
      roll_q     <= 1'b0;
      res_last_q <= 1'b1;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      rep_q      <= rep_d;
      due_q      <= due_d;
      wake_q     <= wake_d;
      prev_q     <= prev_d;
      window_q   <= window_d;
      cnt_q      <= cnt_d;
      scan_due_q <= scan_due_d;
      best_vld_q <= best_vld_d;
      roll_q     <= roll_d;
      res_last_q <= res_last_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    slot_q      <= slot_d;
    per_q       <= per_d;
    rec_q       <= rec_d;
    fnow_q      <= fnow_d;
    now_q       <= now_d;
    best_idx_q  <= best_idx_d;
    best_dl_q   <= best_dl_d;
    tgt_q       <= tgt_d;
    acc_q       <= acc_d;
    res_ok_q    <= res_ok_d;
    res_early_q <= res_early_d;
    res_slot_q  <= res_slot_d;
    res_rem_q   <= res_rem_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire

// File: rtl/dott_ram.sv
`default_nettype none

module dott_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
